// ===== rtl/core/sbt_pkg.sv =====
// ---------------------------------------------------------------------------
// Source byte tokenizer package
// Shared types for the token stream: the token kind codes, one token record
// and the pair of tokens that a single source byte can produce.
// ---------------------------------------------------------------------------
package sbt_pkg;

  localparam int KIND_BITS  = 6;
  localparam int FIELD_BITS = 16;
  localparam int BYTE_BITS  = 8;

  typedef enum logic [KIND_BITS-1:0] {
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_SEMI, K_COLON,
    K_BANG, K_NE, K_ASSIGN, K_EQ, K_GT, K_GE, K_LT, K_LE,
    K_PLUS, K_PLUS_EQ, K_MINUS, K_MINUS_EQ, K_SLASH, K_SLASH_EQ,
    K_STAR, K_STAR_EQ, K_PERCENT, K_PERCENT_EQ, K_AND, K_OR,
    K_COMMENT, K_EOF, K_NUMBER, K_IDENT,
    K_CONST, K_FN, K_RETURN, K_VOID, K_I32, K_ERROR
  } token_kind_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] line;
    logic                  last;
  } token_t;

  typedef struct packed {
    logic   first_valid;
    logic   second_valid;
    token_t first;
    token_t second;
  } token_pair_t;

endpackage

// ===== rtl/core/sbt_byte_if.sv =====
// ---------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel that carries one source byte per transaction.
// ---------------------------------------------------------------------------
interface sbt_byte_if;
  logic                          valid;
  logic                          ready;
  logic [sbt_pkg::BYTE_BITS-1:0] next_byte;

  modport source (output valid, output next_byte, input ready);
  modport sink (input valid, input next_byte, output ready);
endinterface

// ===== rtl/core/sbt_token_if.sv =====
// ---------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one token per transaction.
// ---------------------------------------------------------------------------
interface sbt_token_if;
  logic                           valid;
  logic                           ready;
  logic [sbt_pkg::KIND_BITS-1:0]  token_kind;
  logic [sbt_pkg::FIELD_BITS-1:0] token_start;
  logic [sbt_pkg::FIELD_BITS-1:0] token_length;
  logic [sbt_pkg::FIELD_BITS-1:0] line_number;
  logic                           last_of_run;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input line_number, input last_of_run, output ready
  );
endinterface

// ===== rtl/core/source_byte_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Source byte tokenizer
// Streaming lexer: source bytes in, tokens with kind, offset, length and
// line out, through an input register, the scanner and a token queue.
// ---------------------------------------------------------------------------
// A token is offered from the token queue once the byte that completes
// it has passed the input register. Throughput: one byte per cycle while
// the queue holds at most two tokens; a byte that yields two tokens writes
// both into the four-entry queue at once. Synchronous reset returns the
// scanner to idle at offset zero, line one, with the queue empty.
module source_byte_tokenizer #(
  parameter int POSITION_BITS = 16,
  parameter int TOKEN_LIMIT   = 65535
) (
  input logic             clk,
  input logic             rst,
  sbt_byte_if.sink        bytes,
  sbt_token_if.source     tokens
);

  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic                          held_valid;
  logic [sbt_pkg::BYTE_BITS-1:0] held_byte;
  logic                          step;
  sbt_pkg::token_pair_t          pair;

  sbt_pkg::token_t               queue [DEPTH];
  logic [PTR_BITS-1:0]           head, tail;
  logic [CNT_BITS-1:0]           fill;
  logic                          pop;
  logic [PTR_BITS-1:0]           tail_plus;

  assign step         = held_valid && (fill <= CNT_BITS'(DEPTH - 2));
  assign bytes.ready  = !held_valid || step;
  assign pop          = tokens.valid && tokens.ready;
  assign tail_plus    = tail + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (bytes.ready) begin
      held_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready) begin
      held_byte <= bytes.next_byte;
    end
  end

  sbt_scan #(
    .POSITION_BITS(POSITION_BITS),
    .TOKEN_LIMIT  (TOKEN_LIMIT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .next_byte(held_byte),
    .tokens   (pair)
  );

  always_ff @(posedge clk) begin
    if (pair.first_valid) begin
      queue[tail] <= pair.first;
    end
    if (pair.second_valid) begin
      queue[tail_plus] <= pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + PTR_BITS'(pair.first_valid) + PTR_BITS'(pair.second_valid);
      head <= head + PTR_BITS'(pop);
      fill <= fill + CNT_BITS'(pair.first_valid) + CNT_BITS'(pair.second_valid)
              - CNT_BITS'(pop);
    end
  end

  assign tokens.valid        = (fill != '0);
  assign tokens.token_kind   = queue[head].kind;
  assign tokens.token_start  = queue[head].start;
  assign tokens.token_length = queue[head].length;
  assign tokens.line_number  = queue[head].line;
  assign tokens.last_of_run  = queue[head].last;

endmodule

// ===== rtl/core/sbt_scan.sv =====
// ---------------------------------------------------------------------------
// Tokenizer scanner
// Holds the scan state and turns one source byte per step into up to two
// tokens, with the keyword window, line counter and token limit.
// ---------------------------------------------------------------------------
module sbt_scan #(
  parameter int POSITION_BITS = 16,
  parameter int TOKEN_LIMIT   = 65535
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [sbt_pkg::BYTE_BITS-1:0] next_byte,
  output sbt_pkg::token_pair_t          tokens
);

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_OP     = 4'd1;
  localparam logic [3:0] M_AMP    = 4'd2;
  localparam logic [3:0] M_BAR    = 4'd3;
  localparam logic [3:0] M_SLASH  = 4'd4;
  localparam logic [3:0] M_NUM    = 4'd5;
  localparam logic [3:0] M_NUMDOT = 4'd6;
  localparam logic [3:0] M_IDENT  = 4'd7;
  localparam logic [3:0] M_LCOM   = 4'd8;
  localparam logic [3:0] M_BCOM   = 4'd9;

  localparam int KW_COUNT = 5;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h00636F6E7374, 48'h00000000666E, 48'h72657475726E, 48'h0000766F6964,
    48'h000000693332
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd5, 16'd2, 16'd6, 16'd4, 16'd3};
  localparam logic [16:0] LIMIT = 17'(TOKEN_LIMIT);

  logic [3:0]               mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [15:0]              line, line_next;
  logic [15:0]              pend_start, pend_start_next;
  logic [15:0]              pend_len, pend_len_next;
  logic [15:0]              pend_line, pend_line_next;
  logic [5:0]               pend_kind, pend_kind_next;
  logic [47:0]              window, window_next;
  logic                     star, star_next;
  logic [15:0]              count, count_next;
  logic                     halted, halted_next;
  sbt_pkg::token_pair_t     pair;

  function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [1:0] d);
    logic [16:0] s;
    s = {1'b0, v} + {15'd0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic sbt_pkg::token_t make_token(input logic [5:0] k, input logic [15:0] st,
                                                 input logic [15:0] ln, input logic [15:0] li);
    sbt_pkg::token_t t;
    t.kind   = k;
    t.start  = st;
    t.length = ln;
    t.line   = li;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  always_comb begin
    logic [7:0]               b;
    logic [15:0]              pos16;
    logic [POSITION_BITS-1:0] pos_prev;
    logic                     used;
    logic                     want0, want1, want_idle;
    logic                     ok0, ok1;
    logic                     restart;
    logic [5:0]               ikind;
    logic [5:0]               last_kind;
    logic [16:0]              count_sum;
    sbt_pkg::token_t          r0, r1, ri;

    b               = next_byte;
    pos16           = 16'(pos);
    pos_prev        = pos - 1'b1;
    used            = 1'b1;
    want0           = 1'b0;
    want1           = 1'b0;
    want_idle       = 1'b0;
    restart         = 1'b0;
    r0              = make_token(sbt_pkg::K_EOF, 16'd0, 16'd0, 16'd0);
    r1              = r0;
    ri              = r0;
    mode_next       = mode;
    pos_next        = pos;
    line_next       = line;
    pend_start_next = pend_start;
    pend_len_next   = pend_len;
    pend_line_next  = pend_line;
    pend_kind_next  = pend_kind;
    window_next     = window;
    star_next       = star;
    halted_next     = halted;

    ikind = sbt_pkg::K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (pend_len == KW_LEN[i] && window == KW_TEXT[i]) begin
        ikind = sbt_pkg::K_CONST + 6'(i);
      end
    end

    if (!halted) begin
      used = 1'b0;
      unique case (mode)
        M_OP: begin
          want0     = 1'b1;
          mode_next = M_IDLE;
          if (b == "=") begin
            r0   = make_token(pend_kind + 6'd1, pend_start, 16'd2, pend_line);
            used = 1'b1;
          end else begin
            r0 = make_token(pend_kind, pend_start, pend_len, pend_line);
          end
        end
        M_AMP, M_BAR: begin
          want0     = 1'b1;
          mode_next = M_IDLE;
          used      = 1'b1;
          if ((mode == M_AMP && b == "&") || (mode == M_BAR && b == "|")) begin
            r0 = make_token(pend_kind, pend_start, 16'd2, pend_line);
          end else begin
            r0          = make_token(sbt_pkg::K_ERROR, pend_start, pend_len, pend_line);
            halted_next = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == "=") begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            used      = 1'b1;
            r0        = make_token(sbt_pkg::K_SLASH_EQ, pend_start, 16'd2, pend_line);
          end else if (b == "/") begin
            mode_next     = M_LCOM;
            pend_len_next = 16'd2;
            used          = 1'b1;
          end else if (b == "*") begin
            mode_next     = M_BCOM;
            pend_len_next = 16'd2;
            star_next     = 1'b0;
            used          = 1'b1;
          end else begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            r0        = make_token(sbt_pkg::K_SLASH, pend_start, pend_len, pend_line);
          end
        end
        M_NUM: begin
          if (is_digit(b)) begin
            pend_len_next = sat_add(pend_len, 2'd1);
            used          = 1'b1;
          end else if (b == ".") begin
            mode_next = M_NUMDOT;
            used      = 1'b1;
          end else begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            r0        = make_token(sbt_pkg::K_NUMBER, pend_start, pend_len, pend_line);
          end
        end
        M_NUMDOT: begin
          used = 1'b1;
          if (is_digit(b)) begin
            pend_len_next = sat_add(pend_len, 2'd2);
            mode_next     = M_NUM;
          end else begin
            want0       = 1'b1;
            want1       = 1'b1;
            mode_next   = M_IDLE;
            r0          = make_token(sbt_pkg::K_NUMBER, pend_start, pend_len, pend_line);
            r1          = make_token(sbt_pkg::K_ERROR, 16'(pos_prev), 16'd1, line);
            halted_next = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            pend_len_next = sat_add(pend_len, 2'd1);
            window_next   = {window[39:0], b};
            used          = 1'b1;
          end else begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            r0        = make_token(ikind, pend_start, pend_len, pend_line);
          end
        end
        M_LCOM: begin
          if (b == "\n" || b == 8'd0) begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            r0        = make_token(sbt_pkg::K_COMMENT, pend_start, pend_len, pend_line);
          end else begin
            pend_len_next = sat_add(pend_len, 2'd1);
            used          = 1'b1;
          end
        end
        M_BCOM: begin
          if (b == 8'd0) begin
            want0     = 1'b1;
            mode_next = M_IDLE;
            r0        = make_token(sbt_pkg::K_COMMENT, pend_start, pend_len, pend_line);
          end else begin
            pend_len_next = sat_add(pend_len, 2'd1);
            used          = 1'b1;
            if (b == "/" && star) begin
              want0     = 1'b1;
              mode_next = M_IDLE;
              r0        = make_token(sbt_pkg::K_COMMENT, pend_start, pend_len_next, pend_line);
            end else begin
              star_next = (b == "*");
              if (b == "\n") begin
                line_next = sat_add(line, 2'd1);
              end
            end
          end
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase

      if (!used) begin
        unique case (b)
          8'd0: begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_EOF, pos16, 16'd0, line);
            restart   = 1'b1;
          end
          " ", "\t", 8'h0B, 8'h0C, "\r": begin
          end
          "\n": line_next = sat_add(line, 2'd1);
          "(": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_LPAREN, pos16, 16'd1, line);
          end
          ")": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_RPAREN, pos16, 16'd1, line);
          end
          "{": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_LBRACE, pos16, 16'd1, line);
          end
          "}": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_RBRACE, pos16, 16'd1, line);
          end
          ";": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_SEMI, pos16, 16'd1, line);
          end
          ":": begin
            want_idle = 1'b1;
            ri        = make_token(sbt_pkg::K_COLON, pos16, 16'd1, line);
          end
          "!", "=", ">", "<", "+", "-", "*", "%", "/", "&", "|": begin
            pend_start_next = pos16;
            pend_len_next   = 16'd1;
            pend_line_next  = line;
            mode_next       = M_OP;
            unique case (b)
              "!":     pend_kind_next = sbt_pkg::K_BANG;
              "=":     pend_kind_next = sbt_pkg::K_ASSIGN;
              ">":     pend_kind_next = sbt_pkg::K_GT;
              "<":     pend_kind_next = sbt_pkg::K_LT;
              "+":     pend_kind_next = sbt_pkg::K_PLUS;
              "-":     pend_kind_next = sbt_pkg::K_MINUS;
              "*":     pend_kind_next = sbt_pkg::K_STAR;
              "%":     pend_kind_next = sbt_pkg::K_PERCENT;
              "/": begin
                pend_kind_next = sbt_pkg::K_SLASH;
                mode_next      = M_SLASH;
              end
              "&": begin
                pend_kind_next = sbt_pkg::K_AND;
                mode_next      = M_AMP;
              end
              default: begin
                pend_kind_next = sbt_pkg::K_OR;
                mode_next      = M_BAR;
              end
            endcase
          end
          default: begin
            if (is_digit(b)) begin
              pend_start_next = pos16;
              pend_len_next   = 16'd1;
              pend_line_next  = line;
              pend_kind_next  = sbt_pkg::K_NUMBER;
              mode_next       = M_NUM;
            end else if (is_alpha(b)) begin
              pend_start_next = pos16;
              pend_len_next   = 16'd1;
              pend_line_next  = line;
              pend_kind_next  = sbt_pkg::K_IDENT;
              mode_next       = M_IDENT;
              window_next     = {40'd0, b};
            end else begin
              want_idle   = 1'b1;
              ri          = make_token(sbt_pkg::K_ERROR, pos16, 16'd1, line);
              halted_next = 1'b1;
            end
          end
        endcase

        if (want0) begin
          want1 = want_idle;
          r1    = ri;
        end else begin
          want0 = want_idle;
          r0    = ri;
        end
      end
    end else if (b == 8'd0) begin
      restart = 1'b1;
    end

    ok0        = want0 && ({1'b0, count} < LIMIT);
    ok1        = want1 && (({1'b0, count} + {16'd0, ok0}) < LIMIT);
    count_sum  = {1'b0, count} + {16'd0, ok0} + {16'd0, ok1};
    count_next = count_sum[15:0];
    last_kind  = ok1 ? r1.kind : r0.kind;

    if (halted_next && used && b == 8'd0 && mode_next == M_IDLE && ok0 &&
        last_kind == sbt_pkg::K_ERROR) begin
      restart = 1'b1;
    end

    if (restart) begin
      mode_next       = M_IDLE;
      pos_next        = '0;
      line_next       = 16'd1;
      pend_start_next = 16'd0;
      pend_len_next   = 16'd0;
      pend_line_next  = 16'd1;
      pend_kind_next  = 6'd0;
      window_next     = 48'd0;
      star_next       = 1'b0;
      count_next      = 16'd0;
      halted_next     = 1'b0;
    end else begin
      pos_next = pos + 1'b1;
    end

    r0.last           = !ok1;
    r1.last           = 1'b1;
    pair.first_valid  = ok0;
    pair.second_valid = ok1;
    pair.first        = r0;
    pair.second       = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      pos        <= '0;
      line       <= 16'd1;
      pend_start <= 16'd0;
      pend_len   <= 16'd0;
      pend_line  <= 16'd1;
      pend_kind  <= 6'd0;
      window     <= 48'd0;
      star       <= 1'b0;
      count      <= 16'd0;
      halted     <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      pos        <= pos_next;
      line       <= line_next;
      pend_start <= pend_start_next;
      pend_len   <= pend_len_next;
      pend_line  <= pend_line_next;
      pend_kind  <= pend_kind_next;
      window     <= window_next;
      star       <= star_next;
      count      <= count_next;
      halted     <= halted_next;
    end
  end

  always_comb begin
    tokens              = pair;
    tokens.first_valid  = pair.first_valid && step;
    tokens.second_valid = pair.second_valid && step;
  end

endmodule
